// ===== sv/i2c_master_transaction_sequencer_macros.svh =====
// assertion macros for the transaction sequencer
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH

// same-cycle implication
`define I2CMTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/i2cmts_pkg.sv =====
`default_nettype none

package i2cmts_pkg;

    localparam int TX_DEPTH = 16;
    localparam int TX_POS_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int TX_REM_W = $clog2(TX_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_LENGTH     = 2'd2;

    // two-wire status codes
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RESTART      = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_STATUS = 2'd1,
        MODE_ABORT  = 2'd2,
        MODE_LOAD   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WRITE = 2'd1,
        PH_READ  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_SEND    = 3'd2,
        CMD_RX_ACK  = 3'd3,
        CMD_RX_NACK = 3'd4,
        CMD_STOP    = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_NACK     = 2'd1,
        ERR_NO_REPLY = 2'd2,
        ERR_OTHER    = 2'd3
    } t_err;

endpackage

`default_nettype wire

// ===== sv/i2c_master_transaction_sequencer.sv =====
// channel   direction  handshake                   payload
// in        to block   i_in_valid / o_in_stall     mode, with_write, status_code, bus_rx_byte,
//                                                  load_index, load_value
// out       from block o_out_valid / i_out_stall   bus_command, bus_tx_byte, read_valid,
//                                                  read_index, read_byte, refused_busy,
//                                                  done_res, error_code, idle
// cfg       to block   i_cfg_we                    i_cfg_index, i_cfg_data
//
// one transaction per cycle sustained while i_out_stall does not hold the result register; a result
// passes through the input register, then decision logic into the result register
// i_rst_n is synchronous, active low; it clears phase, error, counters and valids
// the transmit store is not cleared; unwritten slots read as unknown
// i_out_stall holds the result register and stalls the input only when both stages are full
`default_nettype none

`include "i2c_master_transaction_sequencer_macros.svh"

module i2c_master_transaction_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_we,
    input  wire logic [i2cmts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [i2cmts_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic        i_with_write,
    input  wire logic [7:0]  i_status_code,
    input  wire logic [7:0]  i_bus_rx_byte,
    input  wire logic [3:0]  i_load_index,
    input  wire logic [7:0]  i_load_value,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_bus_command,
    output logic [7:0]       o_bus_tx_byte,
    output logic             o_read_valid,
    output logic [7:0]       o_read_index,
    output logic [7:0]       o_read_byte,
    output logic             o_refused_busy,
    output logic             o_done_res,
    output logic [1:0]       o_error_code,
    output logic             o_idle
);

    localparam int TX_DEPTH = i2cmts_pkg::TX_DEPTH;
    localparam int TX_POS_W = i2cmts_pkg::TX_POS_W;
    localparam int TX_REM_W = i2cmts_pkg::TX_REM_W;

    // configuration
    logic [6:0] r_slave_address;
    logic [4:0] r_tx_length;
    logic [7:0] r_rx_length;

    // input register
    logic                  r_in_vld;
    i2cmts_pkg::t_mode     r_mode;
    logic                  r_with_write;
    logic [7:0]            r_status_code;
    logic [7:0]            r_bus_rx_byte;
    logic [3:0]            r_load_index;
    logic [7:0]            r_load_value;

    // sequencer state
    i2cmts_pkg::t_phase    r_phase, n_phase;
    i2cmts_pkg::t_err      r_err, n_err;
    logic [TX_REM_W-1:0]   r_tx_rem, n_tx_rem;
    logic [TX_POS_W-1:0]   r_tx_pos, n_tx_pos;
    logic [7:0]            r_rx_rem, n_rx_rem;
    logic [7:0]            r_rx_cnt, n_rx_cnt;
    logic [7:0]            r_tx_store [TX_DEPTH];
    logic                  n_store_we;

    // result register
    logic                  r_out_vld;
    i2cmts_pkg::t_cmd      r_bus_command, n_bus_command;
    logic [7:0]            r_bus_tx_byte, n_bus_tx_byte;
    logic                  r_read_valid, n_read_valid;
    logic [7:0]            r_read_index, n_read_index;
    logic [7:0]            r_read_byte, n_read_byte;
    logic                  r_refused_busy, n_refused_busy;
    logic                  r_done_res, n_done_res;
    logic [1:0]            r_error_code;
    logic                  r_idle;

    logic w_adv;
    logic w_fire;
    logic w_ev_end;
    logic w_take;
    logic w_continue;

    assign w_adv      = ~r_out_vld | ~i_out_stall;
    assign w_fire     = r_in_vld & w_adv;
    assign o_in_stall = r_in_vld & ~w_adv;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= '0;
            r_tx_length     <= '0;
            r_rx_length     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cmts_pkg::CFG_SLAVE_ADDRESS: r_slave_address <= i_cfg_data[6:0];
                i2cmts_pkg::CFG_TX_LENGTH:     r_tx_length     <= i_cfg_data[4:0];
                i2cmts_pkg::CFG_RX_LENGTH:     r_rx_length     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_mode        <= i2cmts_pkg::t_mode'(i_mode);
            r_with_write  <= i_with_write;
            r_status_code <= i_status_code;
            r_bus_rx_byte <= i_bus_rx_byte;
            r_load_index  <= i_load_index;
            r_load_value  <= i_load_value;
        end
    end

    // status events that finish the current phase, and received bytes that are taken
    always_comb begin
        w_ev_end = 1'b0;
        w_take   = 1'b0;
        if (r_mode == i2cmts_pkg::MODE_STATUS) begin
            case (r_phase)
                i2cmts_pkg::PH_WRITE: begin
                    case (r_status_code)
                        i2cmts_pkg::ST_START, i2cmts_pkg::ST_RESTART: w_ev_end = 1'b0;
                        i2cmts_pkg::ST_MT_SLA_ACK, i2cmts_pkg::ST_MT_DATA_ACK:
                            w_ev_end = (r_tx_rem == '0);
                        default: w_ev_end = 1'b1;
                    endcase
                end
                i2cmts_pkg::PH_READ: begin
                    case (r_status_code)
                        i2cmts_pkg::ST_START, i2cmts_pkg::ST_RESTART,
                        i2cmts_pkg::ST_MR_SLA_ACK: w_ev_end = 1'b0;
                        i2cmts_pkg::ST_MR_DATA_ACK: begin
                            w_take = (r_rx_rem != '0);
                        end
                        i2cmts_pkg::ST_MR_DATA_NACK: begin
                            w_ev_end = 1'b1;
                            w_take   = (r_rx_rem != '0);
                        end
                        default: w_ev_end = 1'b1;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_err      = r_err;
        n_tx_rem   = r_tx_rem;
        n_tx_pos   = r_tx_pos;
        n_rx_rem   = r_rx_rem;
        n_rx_cnt   = r_rx_cnt;
        n_store_we = 1'b0;
        case (r_mode)
            i2cmts_pkg::MODE_START: begin
                if (r_phase == i2cmts_pkg::PH_IDLE) begin
                    n_err    = i2cmts_pkg::ERR_NONE;
                    n_tx_pos = '0;
                    n_rx_cnt = '0;
                    n_rx_rem = r_rx_length;
                    n_tx_rem = '0;
                    if (r_with_write) begin
                        if (int'(r_tx_length) > TX_DEPTH) begin
                            n_tx_rem = TX_REM_W'(TX_DEPTH);
                        end else begin
                            n_tx_rem = TX_REM_W'(r_tx_length);
                        end
                        n_phase = i2cmts_pkg::PH_WRITE;
                    end else if (r_rx_length != '0) begin
                        n_phase = i2cmts_pkg::PH_READ;
                    end
                end
            end
            i2cmts_pkg::MODE_STATUS: begin
                case (r_phase)
                    i2cmts_pkg::PH_WRITE: begin
                        case (r_status_code)
                            i2cmts_pkg::ST_START, i2cmts_pkg::ST_RESTART: ;
                            i2cmts_pkg::ST_MT_SLA_ACK, i2cmts_pkg::ST_MT_DATA_ACK: begin
                                if (r_tx_rem != '0) begin
                                    n_tx_rem = r_tx_rem - 1'b1;
                                    if (int'(r_tx_pos) == TX_DEPTH - 1) begin
                                        n_tx_pos = '0;
                                    end else begin
                                        n_tx_pos = r_tx_pos + 1'b1;
                                    end
                                end
                            end
                            i2cmts_pkg::ST_MT_DATA_NACK: begin
                                if (r_tx_rem != '0) begin
                                    n_err = i2cmts_pkg::ERR_NACK;
                                end
                            end
                            i2cmts_pkg::ST_MT_SLA_NACK: n_err = i2cmts_pkg::ERR_NO_REPLY;
                            default: n_err = i2cmts_pkg::ERR_OTHER;
                        endcase
                        if (w_ev_end) begin
                            if (n_err == i2cmts_pkg::ERR_NONE && r_rx_rem != '0) begin
                                n_phase = i2cmts_pkg::PH_READ;
                            end else begin
                                n_phase = i2cmts_pkg::PH_IDLE;
                            end
                        end
                    end
                    i2cmts_pkg::PH_READ: begin
                        case (r_status_code)
                            i2cmts_pkg::ST_START, i2cmts_pkg::ST_RESTART,
                            i2cmts_pkg::ST_MR_SLA_ACK, i2cmts_pkg::ST_MR_DATA_ACK,
                            i2cmts_pkg::ST_MR_DATA_NACK: ;
                            i2cmts_pkg::ST_MR_SLA_NACK: n_err = i2cmts_pkg::ERR_NO_REPLY;
                            default: n_err = i2cmts_pkg::ERR_OTHER;
                        endcase
                        if (w_take) begin
                            n_rx_cnt = r_rx_cnt + 1'b1;
                            n_rx_rem = r_rx_rem - 1'b1;
                        end
                        if (w_ev_end) begin
                            n_phase = i2cmts_pkg::PH_IDLE;
                        end
                    end
                    default: n_phase = i2cmts_pkg::PH_IDLE;
                endcase
            end
            i2cmts_pkg::MODE_ABORT: n_phase = i2cmts_pkg::PH_IDLE;
            i2cmts_pkg::MODE_LOAD: n_store_we = (int'(r_load_index) < TX_DEPTH);
            default: ;
        endcase
    end

    assign w_continue = w_ev_end && (r_phase == i2cmts_pkg::PH_WRITE)
                        && (n_phase == i2cmts_pkg::PH_READ);

    // result fields
    always_comb begin
        n_bus_command  = i2cmts_pkg::CMD_NONE;
        n_bus_tx_byte  = '0;
        n_read_valid   = 1'b0;
        n_read_index   = '0;
        n_read_byte    = '0;
        n_refused_busy = 1'b0;
        n_done_res     = 1'b0;
        case (r_mode)
            i2cmts_pkg::MODE_START: begin
                if (r_phase != i2cmts_pkg::PH_IDLE) begin
                    n_refused_busy = 1'b1;
                end else if (r_with_write || r_rx_length != '0) begin
                    n_bus_command = i2cmts_pkg::CMD_START;
                end else begin
                    n_done_res = 1'b1;
                end
            end
            i2cmts_pkg::MODE_STATUS: begin
                case (r_phase)
                    i2cmts_pkg::PH_WRITE: begin
                        if (r_status_code == i2cmts_pkg::ST_START
                                || r_status_code == i2cmts_pkg::ST_RESTART) begin
                            n_bus_command = i2cmts_pkg::CMD_SEND;
                            n_bus_tx_byte = {r_slave_address, 1'b0};
                        end else if (!w_ev_end) begin
                            n_bus_command = i2cmts_pkg::CMD_SEND;
                            n_bus_tx_byte = r_tx_store[r_tx_pos];
                        end
                    end
                    i2cmts_pkg::PH_READ: begin
                        if (r_status_code == i2cmts_pkg::ST_START
                                || r_status_code == i2cmts_pkg::ST_RESTART) begin
                            n_bus_command = i2cmts_pkg::CMD_SEND;
                            n_bus_tx_byte = {r_slave_address, 1'b1};
                        end else if (!w_ev_end) begin
                            n_bus_command = (n_rx_rem > 8'd1) ? i2cmts_pkg::CMD_RX_ACK
                                                              : i2cmts_pkg::CMD_RX_NACK;
                        end
                        if (w_take) begin
                            n_read_valid = 1'b1;
                            n_read_index = r_rx_cnt;
                            n_read_byte  = r_bus_rx_byte;
                        end
                    end
                    default: n_bus_command = i2cmts_pkg::CMD_STOP;
                endcase
                if (w_ev_end) begin
                    if (w_continue) begin
                        n_bus_command = i2cmts_pkg::CMD_START;
                    end else begin
                        n_bus_command = i2cmts_pkg::CMD_STOP;
                        n_done_res    = 1'b1;
                    end
                end
            end
            i2cmts_pkg::MODE_ABORT: n_bus_command = i2cmts_pkg::CMD_STOP;
            default: ;
        endcase
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2cmts_pkg::PH_IDLE;
            r_err     <= i2cmts_pkg::ERR_NONE;
            r_tx_rem  <= '0;
            r_tx_pos  <= '0;
            r_rx_rem  <= '0;
            r_rx_cnt  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase   <= n_phase;
                r_err     <= n_err;
                r_tx_rem  <= n_tx_rem;
                r_tx_pos  <= n_tx_pos;
                r_rx_rem  <= n_rx_rem;
                r_rx_cnt  <= n_rx_cnt;
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_store_we) begin
            r_tx_store[TX_POS_W'(r_load_index)] <= r_load_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_bus_command  <= n_bus_command;
            r_bus_tx_byte  <= n_bus_tx_byte;
            r_read_valid   <= n_read_valid;
            r_read_index   <= n_read_index;
            r_read_byte    <= n_read_byte;
            r_refused_busy <= n_refused_busy;
            r_done_res     <= n_done_res;
            r_error_code   <= n_err;
            r_idle         <= (n_phase == i2cmts_pkg::PH_IDLE);
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_bus_command  = r_bus_command;
    assign o_bus_tx_byte  = r_bus_tx_byte;
    assign o_read_valid   = r_read_valid;
    assign o_read_index   = r_read_index;
    assign o_read_byte    = r_read_byte;
    assign o_refused_busy = r_refused_busy;
    assign o_done_res     = r_done_res;
    assign o_error_code   = r_error_code;
    assign o_idle         = r_idle;

    `I2CMTS_ASSERT_IMPLY(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall,
        r_out_vld && i_out_stall, "input stalled while result stage can advance")
    `I2CMTS_ASSERT_IMPLY(a_done_is_idle, i_clk, i_rst_n, o_out_valid && o_done_res,
        o_idle && !o_refused_busy, "done reported while a transaction runs")
    `I2CMTS_ASSERT_IMPLY(a_busy_no_cmd, i_clk, i_rst_n, o_out_valid && o_refused_busy,
        o_bus_command == i2cmts_pkg::CMD_NONE && !o_idle, "refused start issued a command")
    `I2CMTS_ASSERT_IMPLY(a_read_cmd, i_clk, i_rst_n, o_out_valid && o_read_valid,
        o_bus_command == i2cmts_pkg::CMD_RX_ACK || o_bus_command == i2cmts_pkg::CMD_RX_NACK
        || o_bus_command == i2cmts_pkg::CMD_STOP, "received byte without a read command")
    `I2CMTS_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, r_out_vld,
        "processed transaction left no result")

endmodule

`default_nettype wire

// ===== verif/i2c_master_transaction_sequencer_tb.sv =====
`timescale 1ns / 100ps

module i2c_master_transaction_sequencer_tb;

    localparam int RANDOM_TXNS = 1100;
    localparam int MAX_CYCLES  = 500000;

    localparam logic [7:0] KNOWN_ST [10] = '{
        i2cmts_pkg::ST_START, i2cmts_pkg::ST_RESTART, i2cmts_pkg::ST_MT_SLA_ACK,
        i2cmts_pkg::ST_MT_SLA_NACK, i2cmts_pkg::ST_MT_DATA_ACK, i2cmts_pkg::ST_MT_DATA_NACK,
        i2cmts_pkg::ST_MR_SLA_ACK, i2cmts_pkg::ST_MR_SLA_NACK, i2cmts_pkg::ST_MR_DATA_ACK,
        i2cmts_pkg::ST_MR_DATA_NACK
    };

    typedef struct {
        i2cmts_pkg::t_mode mode;
        logic              with_write;
        logic [7:0]        status;
        logic [7:0]        rx_byte;
        logic [3:0]        load_idx;
        logic [7:0]        load_val;
    } t_txn;

    typedef struct {
        i2cmts_pkg::t_cmd  cmd;
        logic [7:0]        tx_byte;
        logic              rd_valid;
        logic [7:0]        rd_idx;
        logic [7:0]        rd_byte;
        logic              busy;
        logic              done;
        i2cmts_pkg::t_err  err;
        logic              idle;
    } t_reply;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [i2cmts_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [i2cmts_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [1:0]                        i_mode = '0;
    logic                              i_with_write = 1'b0;
    logic [7:0]                        i_status_code = '0;
    logic [7:0]                        i_bus_rx_byte = '0;
    logic [3:0]                        i_load_index = '0;
    logic [7:0]                        i_load_value = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic [2:0]                        o_bus_command;
    logic [7:0]                        o_bus_tx_byte;
    logic                              o_read_valid;
    logic [7:0]                        o_read_index;
    logic [7:0]                        o_read_byte;
    logic                              o_refused_busy;
    logic                              o_done_res;
    logic [1:0]                        o_error_code;
    logic                              o_idle;

    i2c_master_transaction_sequencer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_with_write   (i_with_write),
        .i_status_code  (i_status_code),
        .i_bus_rx_byte  (i_bus_rx_byte),
        .i_load_index   (i_load_index),
        .i_load_value   (i_load_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bus_command  (o_bus_command),
        .o_bus_tx_byte  (o_bus_tx_byte),
        .o_read_valid   (o_read_valid),
        .o_read_index   (o_read_index),
        .o_read_byte    (o_read_byte),
        .o_refused_busy (o_refused_busy),
        .o_done_res     (o_done_res),
        .o_error_code   (o_error_code),
        .o_idle         (o_idle)
    );

    t_txn   txn_q[$];
    t_reply reply_q[$];
    t_txn   cur_txn;
    int     n_queued = 0;
    int     n_accepted = 0;
    int     n_fail = 0;
    int     cycles = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    bit     noisy = 1'b0;

    // shadow of the sequencer
    logic [6:0]         cfg_addr = '0;
    logic [4:0]         cfg_txlen = '0;
    logic [7:0]         cfg_rxlen = '0;
    i2cmts_pkg::t_phase ph_m = i2cmts_pkg::PH_IDLE;
    i2cmts_pkg::t_err   err_m = i2cmts_pkg::ERR_NONE;
    logic [4:0]         tx_left = '0;
    logic [3:0]         tx_pos = '0;
    logic [7:0]         rx_left = '0;
    logic [7:0]         rx_cnt = '0;
    logic [7:0]         tx_buf [i2cmts_pkg::TX_DEPTH];

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void end_or_restart(inout t_reply r);
        if (ph_m == i2cmts_pkg::PH_WRITE && err_m == i2cmts_pkg::ERR_NONE
                && rx_left != 0) begin
            ph_m = i2cmts_pkg::PH_READ;
            r.cmd = i2cmts_pkg::CMD_START;
        end else begin
            ph_m = i2cmts_pkg::PH_IDLE;
            r.cmd = i2cmts_pkg::CMD_STOP;
            r.done = 1'b1;
        end
    endfunction

    function automatic void accept_rx_byte(inout t_reply r, input logic [7:0] b);
        if (rx_left != 0) begin
            r.rd_valid = 1'b1;
            r.rd_idx = rx_cnt;
            r.rd_byte = b;
            rx_cnt = rx_cnt + 8'd1;
            rx_left = rx_left - 8'd1;
        end
    endfunction

    function automatic t_reply next_bus_reply(input t_txn t);
        t_reply r;
        r.cmd = i2cmts_pkg::CMD_NONE;
        r.tx_byte = '0;
        r.rd_valid = 1'b0;
        r.rd_idx = '0;
        r.rd_byte = '0;
        r.busy = 1'b0;
        r.done = 1'b0;
        case (t.mode)
            i2cmts_pkg::MODE_START: begin
                if (ph_m != i2cmts_pkg::PH_IDLE) begin
                    r.busy = 1'b1;
                end else begin
                    err_m = i2cmts_pkg::ERR_NONE;
                    tx_pos = '0;
                    rx_cnt = '0;
                    rx_left = cfg_rxlen;
                    tx_left = '0;
                    if (t.with_write) begin
                        tx_left = (cfg_txlen > i2cmts_pkg::TX_DEPTH) ?
                                  5'(i2cmts_pkg::TX_DEPTH) : cfg_txlen;
                        ph_m = i2cmts_pkg::PH_WRITE;
                        r.cmd = i2cmts_pkg::CMD_START;
                    end else if (cfg_rxlen == 0) begin
                        r.done = 1'b1;
                    end else begin
                        ph_m = i2cmts_pkg::PH_READ;
                        r.cmd = i2cmts_pkg::CMD_START;
                    end
                end
            end
            i2cmts_pkg::MODE_STATUS: begin
                if (ph_m == i2cmts_pkg::PH_WRITE) begin
                    case (t.status)
                        i2cmts_pkg::ST_START, i2cmts_pkg::ST_RESTART: begin
                            r.cmd = i2cmts_pkg::CMD_SEND;
                            r.tx_byte = {cfg_addr, 1'b0};
                        end
                        i2cmts_pkg::ST_MT_SLA_ACK, i2cmts_pkg::ST_MT_DATA_ACK: begin
                            if (tx_left != 0) begin
                                r.cmd = i2cmts_pkg::CMD_SEND;
                                r.tx_byte = tx_buf[tx_pos];
                                tx_pos = tx_pos + 4'd1;
                                tx_left = tx_left - 5'd1;
                            end else begin
                                end_or_restart(r);
                            end
                        end
                        i2cmts_pkg::ST_MT_DATA_NACK: begin
                            if (tx_left != 0) err_m = i2cmts_pkg::ERR_NACK;
                            end_or_restart(r);
                        end
                        i2cmts_pkg::ST_MT_SLA_NACK: begin
                            err_m = i2cmts_pkg::ERR_NO_REPLY;
                            end_or_restart(r);
                        end
                        default: begin
                            err_m = i2cmts_pkg::ERR_OTHER;
                            end_or_restart(r);
                        end
                    endcase
                end else if (ph_m == i2cmts_pkg::PH_READ) begin
                    case (t.status)
                        i2cmts_pkg::ST_START, i2cmts_pkg::ST_RESTART: begin
                            r.cmd = i2cmts_pkg::CMD_SEND;
                            r.tx_byte = {cfg_addr, 1'b1};
                        end
                        i2cmts_pkg::ST_MR_DATA_ACK, i2cmts_pkg::ST_MR_SLA_ACK: begin
                            if (t.status == i2cmts_pkg::ST_MR_DATA_ACK) begin
                                accept_rx_byte(r, t.rx_byte);
                            end
                            r.cmd = (rx_left > 1) ? i2cmts_pkg::CMD_RX_ACK
                                                  : i2cmts_pkg::CMD_RX_NACK;
                        end
                        i2cmts_pkg::ST_MR_DATA_NACK: begin
                            accept_rx_byte(r, t.rx_byte);
                            end_or_restart(r);
                        end
                        i2cmts_pkg::ST_MR_SLA_NACK: begin
                            err_m = i2cmts_pkg::ERR_NO_REPLY;
                            end_or_restart(r);
                        end
                        default: begin
                            err_m = i2cmts_pkg::ERR_OTHER;
                            end_or_restart(r);
                        end
                    endcase
                end else begin
                    r.cmd = i2cmts_pkg::CMD_STOP;
                end
            end
            i2cmts_pkg::MODE_ABORT: begin
                ph_m = i2cmts_pkg::PH_IDLE;
                r.cmd = i2cmts_pkg::CMD_STOP;
            end
            default: begin
                tx_buf[t.load_idx] = t.load_val;
            end
        endcase
        r.err = err_m;
        r.idle = (ph_m == i2cmts_pkg::PH_IDLE);
        return r;
    endfunction

    function automatic t_txn make_txn(input i2cmts_pkg::t_mode m);
        t_txn t;
        t.mode = m;
        t.with_write = 1'($urandom_range(0, 1));
        t.status = $urandom_range(0, 1) ? KNOWN_ST[$urandom_range(0, 9)] : 8'($urandom);
        t.rx_byte = 8'($urandom);
        t.load_idx = 4'($urandom);
        t.load_val = 8'($urandom);
        return t;
    endfunction

    task automatic queue_txn(input t_txn t);
        txn_q.push_back(t);
        n_queued++;
    endtask

    task automatic queue_status(input logic [7:0] code);
        t_txn t;
        if (noisy && $urandom_range(0, 99) < 6) begin
            queue_txn(make_txn(i2cmts_pkg::t_mode'($urandom_range(0, 3))));
        end
        t = make_txn(i2cmts_pkg::MODE_STATUS);
        t.status = (noisy && $urandom_range(0, 99) < 2) ? 8'($urandom) : code;
        queue_txn(t);
    endtask

    task automatic queue_bus_transfer();
        t_txn t;
        int   n_tx;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) queue_txn(make_txn(i2cmts_pkg::MODE_LOAD));
        end
        t = make_txn(i2cmts_pkg::MODE_START);
        queue_txn(t);
        if (t.with_write) begin
            n_tx = (cfg_txlen > i2cmts_pkg::TX_DEPTH) ? i2cmts_pkg::TX_DEPTH : int'(cfg_txlen);
            queue_status(i2cmts_pkg::ST_START);
            queue_status(i2cmts_pkg::ST_MT_SLA_ACK);
            repeat (n_tx) queue_status(i2cmts_pkg::ST_MT_DATA_ACK);
            if (cfg_rxlen != 0) queue_status(i2cmts_pkg::ST_RESTART);
        end else if (cfg_rxlen != 0) begin
            queue_status(i2cmts_pkg::ST_START);
        end
        if (cfg_rxlen != 0) begin
            queue_status(i2cmts_pkg::ST_MR_SLA_ACK);
            repeat (int'(cfg_rxlen) - 1) queue_status(i2cmts_pkg::ST_MR_DATA_ACK);
            queue_status(i2cmts_pkg::ST_MR_DATA_NACK);
        end
    endtask

    task automatic write_reg(input logic [i2cmts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            i2cmts_pkg::CFG_SLAVE_ADDRESS: cfg_addr = val[6:0];
            i2cmts_pkg::CFG_TX_LENGTH:     cfg_txlen = val[4:0];
            default:                       cfg_rxlen = val;
        endcase
    endtask

    task automatic set_config(input logic [6:0] addr, input logic [4:0] txl,
                              input logic [7:0] rxl);
        write_reg(i2cmts_pkg::CFG_SLAVE_ADDRESS, {1'b0, addr});
        write_reg(i2cmts_pkg::CFG_TX_LENGTH, {3'b000, txl});
        write_reg(i2cmts_pkg::CFG_RX_LENGTH, rxl);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (txn_q.size() != 0 || n_accepted != n_queued || reply_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin : drive_blk
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                reply_q.push_back(next_bus_reply(cur_txn));
                n_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (txn_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    cur_txn = txn_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_mode <= cur_txn.mode;
                    i_with_write <= cur_txn.with_write;
                    i_status_code <= cur_txn.status;
                    i_bus_rx_byte <= cur_txn.rx_byte;
                    i_load_index <= cur_txn.load_idx;
                    i_load_value <= cur_txn.load_val;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch_blk
        t_reply want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (reply_q.size() == 0) begin
                    $error("result with no transaction pending");
                    n_fail++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("bus_command", 8'(want.cmd), 8'(o_bus_command));
                    check_field("bus_tx_byte", want.tx_byte, o_bus_tx_byte);
                    check_field("read_valid", 8'(want.rd_valid), 8'(o_read_valid));
                    check_field("read_index", want.rd_idx, o_read_index);
                    check_field("read_byte", want.rd_byte, o_read_byte);
                    check_field("refused_busy", 8'(want.busy), 8'(o_refused_busy));
                    check_field("done_res", 8'(want.done), 8'(o_done_res));
                    check_field("error_code", 8'(want.err), 8'(o_error_code));
                    check_field("idle", 8'(want.idle), 8'(o_idle));
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == MAX_CYCLES) begin
            $display("i2c_master_transaction_sequencer test failed");
            $finish;
        end
    end

    initial begin : main_blk
        t_txn       t;
        int         ph;
        int         base;
        logic [6:0] addr;
        logic [4:0] txl;
        logic [7:0] rxl;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fill the whole transmit store first
        set_config(7'h7F, 5'd31, 8'd0);
        for (int k = 0; k < i2cmts_pkg::TX_DEPTH; k++) begin
            t = make_txn(i2cmts_pkg::MODE_LOAD);
            t.load_idx = 4'(k);
            t.load_val = (k == 0) ? 8'h00 :
                         (k == i2cmts_pkg::TX_DEPTH - 1) ? 8'hFF : 8'($urandom);
            queue_txn(t);
        end
        t = make_txn(i2cmts_pkg::MODE_START);
        t.with_write = 1'b0;
        queue_txn(t);
        queue_status(i2cmts_pkg::ST_MT_DATA_ACK);
        t = make_txn(i2cmts_pkg::MODE_START);
        t.with_write = 1'b1;
        queue_txn(t);
        queue_status(i2cmts_pkg::ST_START);
        t.with_write = 1'b0;
        queue_txn(t);
        queue_status(i2cmts_pkg::ST_MT_SLA_ACK);
        queue_status(i2cmts_pkg::ST_MT_DATA_NACK);
        queue_txn(make_txn(i2cmts_pkg::MODE_ABORT));
        wait_drained();

        noisy = 1'b1;
        base = n_queued;
        ph = 0;
        while (n_queued - base < RANDOM_TXNS) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 84; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            case ($urandom_range(0, 7))
                0: addr = 7'd0;
                1: addr = 7'h7F;
                default: addr = 7'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0: txl = 5'd0;
                1: txl = 5'($urandom_range(16, 31));
                default: txl = 5'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 29))
                0, 1, 2: rxl = 8'd0;
                3: rxl = 8'd255;
                default: rxl = 8'($urandom_range(1, 4));
            endcase
            set_config(addr, txl, rxl);
            if (rxl == 8'd255) begin
                queue_bus_transfer();
            end else begin
                repeat ($urandom_range(1, 4)) queue_bus_transfer();
            end
            wait_drained();
            ph++;
        end

        if (n_fail == 0) begin
            $display("i2c_master_transaction_sequencer test passed");
        end else begin
            $display("i2c_master_transaction_sequencer test failed");
        end
        $finish;
    end

endmodule
